// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the ready queue
// depends on nothing; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define PRQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// antecedent now, consequent checked in the following cycle
`define PRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRQ_ASSERT(lbl, clk, rstn, prop, msg)
`define PRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/prq_pkg.sv =====
// types, codes and sizes of the priority ready queue
// used by prq_cell and priority_ready_queue; depends on nothing
package prq_pkg;

    localparam int ID_W       = 16;
    localparam int PRIO_W     = 6;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int DEPTH_DEF  = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // register index from the word address bit
    localparam logic REG_IDLE_ID = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_IDLE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry new_entry;
    } t_cell_cmd;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        t_status            status;
        logic [PRIO_W-1:0]  head;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/prq_cell.sv =====
// one slot of the sorted shift-register queue
// depends on prq_pkg
module prq_cell (
    input  logic                i_clk,
    input  prq_pkg::t_cell_cmd  i_cmd,
    input  logic                i_occupied,
    input  prq_pkg::t_entry     i_prev,
    input  logic                i_prev_keep,
    input  prq_pkg::t_entry     i_next,
    output prq_pkg::t_entry     o_entry,
    output logic                o_keep,
    output prq_pkg::t_entry     o_next_entry
);

    prq_pkg::t_entry r_entry;
    prq_pkg::t_entry n_entry;

    // holds an entry that stays ahead of the new one (equal or higher priority)
    assign o_keep = i_occupied && (r_entry.prio >= i_cmd.new_entry.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.ins && !o_keep) begin
            n_entry = i_prev_keep ? i_cmd.new_entry : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;

endmodule

// ===== rtl/priority_ready_queue.sv =====
// top level of the priority ready queue: cell row, apb register, result skid
// depends on prq_pkg, prq_cell and assert_macros.svh
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_op, i_thread_id, i_priority_req
// output    out        o_out_valid / i_out_stall   o_out_id, o_out_priority, o_status,
//                                                  o_head_priority, o_count
// config    apb        psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// one request per cycle unless stalled; each cell updates from its neighbors in one step
// the result reaches the output register the cycle after the request is taken,
// or waits in the skid register while the output register is held
// a full output register and a full skid register stall the input (two results buffered)
// synchronous active-low reset clears the entry count, idle id and the output valids
// entry contents are not reset; a slot at or above the count is never read
`include "assert_macros.svh"

module priority_ready_queue #(
    parameter int QUEUE_DEPTH = prq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [prq_pkg::ID_W-1:0]     i_thread_id,
    input  logic [prq_pkg::PRIO_W-1:0]   i_priority_req,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [prq_pkg::ID_W-1:0]     o_out_id,
    output logic [prq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [prq_pkg::STATUS_W-1:0] o_status,
    output logic [prq_pkg::PRIO_W-1:0]   o_head_priority,
    output logic [prq_pkg::COUNT_W-1:0]  o_count,
    // apb register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prq_pkg::ADDR_W-1:0]   paddr,
    input  logic [prq_pkg::DATA_W-1:0]   pwdata,
    output logic [prq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ---------------------------------------------------------------
    // idle id register
    // ---------------------------------------------------------------
    logic [prq_pkg::ID_W-1:0] r_idle_id;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == prq_pkg::REG_IDLE_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_id <= '0;
        end else if (cfg_wr) begin
            r_idle_id <= pwdata[prq_pkg::ID_W-1:0];
        end
    end

    // only the idle id exists; other addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == prq_pkg::REG_IDLE_ID) begin
            prdata = {{(prq_pkg::DATA_W - prq_pkg::ID_W){1'b0}}, r_idle_id};
        end
    end

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic             is_idle_id;
    logic             is_full;
    logic             is_empty;
    logic             do_ins;
    logic             do_pop;

    prq_pkg::t_cell_cmd cmd;

    assign accept     = i_in_valid && !o_in_stall;
    assign is_idle_id = (i_thread_id == r_idle_id);
    assign is_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty   = (r_count == '0);
    // the idle test wins over the full test
    assign do_ins = accept && (i_op == prq_pkg::OP_INSERT) && !is_idle_id && !is_full;
    assign do_pop = accept && (i_op == prq_pkg::OP_POP) && !is_empty;

    assign cmd.ins            = do_ins;
    assign cmd.pop            = do_pop;
    assign cmd.new_entry.id   = i_thread_id;
    assign cmd.new_entry.prio = i_priority_req;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ---------------------------------------------------------------
    // row of cells, slot 0 is the front of the queue
    // ---------------------------------------------------------------
    prq_pkg::t_entry cell_entry [QUEUE_DEPTH];
    prq_pkg::t_entry cell_next  [QUEUE_DEPTH];
    logic            cell_keep  [QUEUE_DEPTH];

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        prq_pkg::t_entry prev_entry;
        prq_pkg::t_entry next_entry;
        logic            prev_keep;

        if (k == 0) begin : g_front
            // the front slot takes the new entry whenever it gives way
            assign prev_entry = cmd.new_entry;
            assign prev_keep  = 1'b1;
        end else begin : g_inner
            assign prev_entry = cell_entry[k-1];
            assign prev_keep  = cell_keep[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_back
            // slot beyond the end is never valid after a pop
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = cell_entry[k+1];
        end

        prq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_occupied   (CNT_W'(k) < r_count),
            .i_prev       (prev_entry),
            .i_prev_keep  (prev_keep),
            .i_next       (next_entry),
            .o_entry      (cell_entry[k]),
            .o_keep       (cell_keep[k]),
            .o_next_entry (cell_next[k])
        );
    end

    // ---------------------------------------------------------------
    // result of the accepted request
    // ---------------------------------------------------------------
    prq_pkg::t_result res;

    always_comb begin
        res.id     = '0;
        res.prio   = '0;
        res.status = prq_pkg::ST_OK;
        if (i_op == prq_pkg::OP_INSERT) begin
            if (is_idle_id) begin
                res.status = prq_pkg::ST_IDLE;
            end else if (is_full) begin
                res.status = prq_pkg::ST_FULL;
            end
        end else if (is_empty) begin
            res.id     = r_idle_id;
            res.status = prq_pkg::ST_EMPTY;
        end else begin
            res.id   = cell_entry[0].id;
            res.prio = cell_entry[0].prio;
        end
        // front priority and count after this request
        res.head  = (n_count != '0) ? cell_next[0].prio : '0;
        res.count = prq_pkg::COUNT_W'(n_count);
    end

    // ---------------------------------------------------------------
    // output register with skid stage
    // ---------------------------------------------------------------
    prq_pkg::t_result r_out;
    prq_pkg::t_result r_skid;
    logic             r_out_v;
    logic             r_skid_v;
    logic             take;

    assign take       = r_out_v && !i_out_stall;
    assign o_in_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || take) begin
            r_out_v  <= r_skid_v || accept;
            r_skid_v <= 1'b0;
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || take) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_out_id        = r_out.id;
    assign o_out_priority  = r_out.prio;
    assign o_status        = r_out.status;
    assign o_head_priority = r_out.head;
    assign o_count         = r_out.count;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `PRQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "count over depth")
    `PRQ_ASSERT(a_skid_order, i_clk, i_rst_n, !r_skid_v || r_out_v, "skid full, output empty")
    `PRQ_ASSERT(a_front_sorted, i_clk, i_rst_n, (r_count < CNT_W'(2)) || (cell_entry[0].prio >= cell_entry[1].prio), "front pair out of order")
    `PRQ_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, accept && (i_op == prq_pkg::OP_INSERT) && !is_idle_id && is_full, r_count == $past(r_count), "full insert changed count")

endmodule

// ===== tb/priority_ready_queue_tb.sv =====
// self-checking testbench of the priority ready queue: directed requests, then random phases
// depends on prq_pkg and priority_ready_queue; the scoreboard class predicts every result
`timescale 1ns / 1ps

module priority_ready_queue_tb;
    import prq_pkg::*;

    localparam int          DEPTH        = DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 250;
    localparam int unsigned PHASE_ITEMS  = 316;
    localparam logic [ADDR_W-1:0] IDLE_ID_ADDR = {REG_IDLE_ID, 2'b00};

    // sorted ready queue model and the store of results still owed by the block
    class prq_scoreboard;
        t_entry          ready_q[$];
        t_result         due_q[$];
        logic [ID_W-1:0] idle_id;
        int unsigned     errors;

        function new();
            idle_id = '0;
            errors  = 0;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // work out the result of one accepted request and update the queue
        function void note_request(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
            t_result     res;
            t_entry      ent;
            int unsigned pos;
            res = '0;
            if (op == OP_INSERT) begin
                if (id == idle_id) begin
                    res.status = ST_IDLE;
                end else if (ready_q.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < ready_q.size() && ready_q[pos].prio >= prio)
                        pos++;
                    ent.id   = id;
                    ent.prio = prio;
                    ready_q.insert(pos, ent);
                    res.status = ST_OK;
                end
            end else if (ready_q.size() == 0) begin
                res.id     = idle_id;
                res.status = ST_EMPTY;
            end else begin
                ent        = ready_q.pop_front();
                res.id     = ent.id;
                res.prio   = ent.prio;
                res.status = ST_OK;
            end
            res.head  = (ready_q.size() > 0) ? ready_q[0].prio : '0;
            res.count = COUNT_W'(ready_q.size());
            due_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                report($sformatf("result with no request outstanding, id %h status %0d",
                                 got.id, got.status));
                return;
            end
            want = due_q.pop_front();
            compare_field("out_id", got.id, want.id);
            compare_field("out_priority", got.prio, want.prio);
            compare_field("status", got.status, want.status);
            compare_field("head_priority", got.head, want.head);
            compare_field("count", got.count, want.count);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [ID_W-1:0]     i_thread_id;
    logic [PRIO_W-1:0]   i_priority_req;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [ID_W-1:0]     o_out_id;
    logic [PRIO_W-1:0]   o_out_priority;
    logic [STATUS_W-1:0] o_status;
    logic [PRIO_W-1:0]   o_head_priority;
    logic [COUNT_W-1:0]  o_count;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    prq_scoreboard sb;

    // idle draws of both sides, with calm stretches where nobody waits
    int unsigned src_calm  = 0;
    int unsigned sink_calm = 0;
    // long receiver hold-offs asked by the request side, taken by the result side
    int unsigned hold_asks  = 0;
    int unsigned holds_done = 0;
    int unsigned cycle_count = 0;

    priority_ready_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_head_priority(o_head_priority),
        .o_count        (o_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // wait drawn before the next request or result; none during a calm stretch
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // offer one request from a falling edge and hold it until it is taken
    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio);
        int unsigned gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_op           = op;
        i_thread_id    = id;
        i_priority_req = prio;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(op, id, prio);
        @(negedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read_check(input logic [ADDR_W-1:0] addr, input logic [ID_W-1:0] want);
        logic [DATA_W-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[ID_W-1:0] !== want)
            sb.report($sformatf("idle_id read back %h want %h", got[ID_W-1:0], want));
    endtask

    // only once the block owes no result
    task automatic set_idle_id(input logic [ID_W-1:0] value);
        while (sb.pending() != 0)
            @(negedge i_clk);
        i_in_valid = 1'b0;
        // upper data bits are noise the register must drop
        reg_write(IDLE_ID_ADDR, {16'($urandom), value});
        sb.idle_id = value;
        reg_read_check(IDLE_ID_ADDR, value);
    endtask

    // random requests in bursts that lean toward filling, toward draining or to neither side
    task automatic random_phase(input int unsigned n_items);
        int unsigned       ins_pct;
        logic              op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        ins_pct = 50;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 25;
                    1: ins_pct = 50;
                    default: ins_pct = 75;
                endcase
            end
            op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
            // now and then the idle id itself, to hit the ignored insert
            id = ($urandom_range(0, 19) == 0) ? sb.idle_id : ID_W'($urandom);
            case ($urandom_range(0, 3))
                0: prio = PRIO_W'($urandom_range(0, 63));
                1: prio = $urandom_range(0, 1) ? '1 : '0;
                // a narrow band gives many ties
                default: prio = PRIO_W'($urandom_range(20, 23));
            endcase
            // mid-phase the receiver sits still while requests keep coming
            if (k == n_items / 2)
                hold_asks++;
            send_request(op, id, prio);
        end
        i_in_valid = 1'b0;
    endtask

    // result side: random stalls, long hold-offs on request, a check per accepted result
    initial begin : result_sink
        int unsigned wait_n;
        t_result     got;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_asks != holds_done) begin
                holds_done++;
                wait_n = LONG_HOLD;
            end else begin
                wait_n = draw_wait(sink_calm);
            end
            if (wait_n > 0) begin
                i_out_stall = 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_out_id, o_out_priority, o_status, o_head_priority, o_count};
            sb.check_result(got);
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_INSERT;
        i_thread_id    = '0;
        i_priority_req = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle id after reset is zero
        reg_read_check(IDLE_ID_ADDR, '0);

        // directed: empty pop and idle insert with the reset idle id
        send_request(OP_POP, 16'h1234, 6'd5);
        send_request(OP_INSERT, 16'h0000, 6'd63);
        // extremes of id and priority, ties at both ends
        send_request(OP_INSERT, 16'hFFFF, 6'd63);
        send_request(OP_INSERT, 16'h0001, 6'd0);
        send_request(OP_INSERT, 16'h8000, 6'd63);
        send_request(OP_INSERT, 16'h7FFF, 6'd0);
        // fill to the top
        for (int k = 0; k < DEPTH - 4; k++)
            send_request(OP_INSERT, 16'hA5A0 + 16'(k), PRIO_W'(k * 11));
        // full insert is dropped; idle insert into a full queue still reads as idle
        send_request(OP_INSERT, 16'h1234, 6'd40);
        send_request(OP_INSERT, 16'h0000, 6'd40);
        repeat (4)
            send_request(OP_POP, 16'h5A5A, 6'd17);
        i_in_valid = 1'b0;

        // random phases under several idle ids, extremes among them
        set_idle_id(16'hFFFF);
        random_phase(PHASE_ITEMS);
        set_idle_id(ID_W'($urandom));
        random_phase(PHASE_ITEMS);
        set_idle_id(16'h0000);
        random_phase(PHASE_ITEMS);
        set_idle_id(16'h8000);
        random_phase(PHASE_ITEMS);
        set_idle_id(ID_W'($urandom));
        random_phase(PHASE_ITEMS);

        // drain, then wait for anything stray
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_cell.sv
rtl/priority_ready_queue.sv
tb/priority_ready_queue_tb.sv
